/* rtl/accel_lp_pkg.sv */
// Shared types, constants and register indexes for the asymmetric low-pass filter.
// Used by every module in the rtl folder; depends on nothing.
`timescale 1ns / 1ps

package accel_lp_pkg;

  // Default sample width and fixed ratio formats.
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int RATIO_W          = 17;  // unsigned Q1.16
  localparam int FRAC_W           = 16;  // unsigned Q0.16
  localparam int CFG_INDEX_W      = 3;
  localparam int CFG_DATA_W       = 17;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_HOLD_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FAST_COEF     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOW_COEF     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOW_INCREASE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOW_DECREASE = 3'd4;

  // Reset values of the configuration registers.
  localparam logic               RST_MAX_HOLD_MODE = 1'b1;
  localparam logic [RATIO_W-1:0] RST_FAST_COEF     = 17'd32768;
  localparam logic [RATIO_W-1:0] RST_SLOW_COEF     = 17'd1024;
  localparam logic [FRAC_W-1:0]  RST_SLOW_INCREASE = 16'd655;
  localparam logic [FRAC_W-1:0]  RST_SLOW_DECREASE = 16'd655;

  // Unity in Q1.16.
  localparam logic [RATIO_W-1:0] ONE_Q16 = 17'd65536;

  // Request kinds carried in tuser.
  localparam logic ACT_STEP    = 1'b0;
  localparam logic ACT_PRELOAD = 1'b1;

  typedef struct packed {
    logic               max_hold_mode;
    logic [RATIO_W-1:0] fast_coef;
    logic [RATIO_W-1:0] slow_coef;
    logic [FRAC_W-1:0]  slow_increase;
    logic [FRAC_W-1:0]  slow_decrease;
  } cfg_t;

endpackage

/* rtl/accel_asym_lowpass_unit.sv */
// Asymmetric accelerating first-order low-pass filter, stream in and stream out.
// A step request accepted into the input register passes through the step logic into
// the output register once that register is free. Throughput: one request per cycle while
// the output is not stalled, set by the single registered pass through the step logic. Preload requests give no result.
// Reset (synchronous, active high) empties both registers, zeroes the held value and
// the accelerating ratio, and loads the configuration reset values.
`timescale 1ns / 1ps

module accel_asym_lowpass_unit
  import accel_lp_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port.
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Input stream.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_W-1:0]     s_tdata,   // [SAMPLE_WIDTH-1:0] sample, rest zero
  input  logic                   s_tuser,   // [0] action
  // Output stream.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_W-1:0]     m_tdata    // [SAMPLE_WIDTH-1:0] filtered, rest zero
);

  localparam int SW = SAMPLE_WIDTH;

  cfg_t                  cfg;
  logic                  in_valid;
  logic                  in_action;
  logic signed [SW-1:0]  in_sample;
  logic                  in_advance;
  logic signed [SW-1:0]  held;
  logic [RATIO_W-1:0]    accel;
  logic signed [SW-1:0]  held_next;
  logic [RATIO_W-1:0]    accel_next;
  logic signed [SW-1:0]  filtered;
  logic [SW-1:0]         out_data;

  accel_lp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  accel_lp_step #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_step (
    .cfg        (cfg),
    .action     (in_action),
    .sample     (in_sample),
    .held       (held),
    .accel      (accel),
    .held_next  (held_next),
    .accel_next (accel_next),
    .filtered   (filtered)
  );

  // A preload never needs the output register, so it always moves on.
  assign in_advance = in_valid && ((in_action == ACT_PRELOAD) || !m_tvalid || m_tready);
  assign s_tready   = !in_valid || in_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (in_advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_sample <= s_tdata[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= '0;
      accel <= '0;
    end else if (in_advance) begin
      held  <= held_next;
      accel <= accel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_advance && (in_action == ACT_STEP)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance && (in_action == ACT_STEP)) begin
      out_data <= filtered;
    end
  end

  assign m_tdata = TDATA_W'(out_data);

endmodule

/* rtl/accel_lp_cfg.sv */
// Configuration register file of the asymmetric low-pass filter.
// Depends on accel_lp_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module accel_lp_cfg
  import accel_lp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_hold_mode <= RST_MAX_HOLD_MODE;
      cfg.fast_coef     <= RST_FAST_COEF;
      cfg.slow_coef     <= RST_SLOW_COEF;
      cfg.slow_increase <= RST_SLOW_INCREASE;
      cfg.slow_decrease <= RST_SLOW_DECREASE;
    end else if (wr_en) begin
      case (wr_index)
        REG_MAX_HOLD_MODE: cfg.max_hold_mode <= wr_data[0];
        REG_FAST_COEF:     cfg.fast_coef     <= wr_data[RATIO_W-1:0];
        REG_SLOW_COEF:     cfg.slow_coef     <= wr_data[RATIO_W-1:0];
        REG_SLOW_INCREASE: cfg.slow_increase <= wr_data[FRAC_W-1:0];
        REG_SLOW_DECREASE: cfg.slow_decrease <= wr_data[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/accel_lp_step.sv */
// Combinational filter step: direction decision, ratio update with clamping,
// and the rounded, saturated output. Depends on accel_lp_pkg.
`timescale 1ns / 1ps

module accel_lp_step
  import accel_lp_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  cfg_t                           cfg,
  input  logic                           action,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [SAMPLE_WIDTH-1:0] held,
  input  logic        [RATIO_W-1:0]      accel,
  output logic signed [SAMPLE_WIDTH-1:0] held_next,
  output logic        [RATIO_W-1:0]      accel_next,
  output logic signed [SAMPLE_WIDTH-1:0] filtered
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int PW = SW + RATIO_W + 2;  // ratio times difference
  localparam int TW = SW + 20;           // accumulated total
  localparam int QW = SW + 5;            // rounded value before saturation

  localparam logic signed [QW-1:0] Q_MAX = {{(QW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {{(QW-SW+1){1'b1}}, {(SW-1){1'b0}}};

  logic                      fast;
  logic [RATIO_W-1:0]        ratio;
  logic [RATIO_W-1:0]        factor;
  logic [2*RATIO_W-1:0]      accel_prod;
  logic [RATIO_W:0]          scaled;
  logic [RATIO_W:0]          lo_clamped;
  logic [RATIO_W:0]          hi_clamped;
  logic signed [SW:0]        diff;
  logic signed [RATIO_W:0]   ratio_s;
  logic signed [PW-1:0]      prod;
  logic signed [TW-1:0]      total;
  logic                      neg;
  logic [TW-1:0]             mag;
  logic [TW-1:0]             mag_rnd;
  logic [QW-1:0]             rnd;
  logic signed [QW-1:0]      q;

  // An equal sample counts as the fast direction in both modes.
  assign fast = cfg.max_hold_mode ? (sample >= held) : (sample <= held);

  assign ratio  = fast ? cfg.fast_coef : accel;
  assign factor = fast ? (ONE_Q16 - {1'b0, cfg.slow_decrease})
                       : (ONE_Q16 + {1'b0, cfg.slow_increase});

  assign accel_prod = {{RATIO_W{1'b0}}, accel} * {{RATIO_W{1'b0}}, factor};
  assign scaled     = accel_prod[2*RATIO_W-1:16];

  // Lower clamp first, then the upper clamp, which wins if the bounds cross.
  assign lo_clamped = (scaled < {1'b0, cfg.slow_coef}) ? {1'b0, cfg.slow_coef} : scaled;
  assign hi_clamped = (lo_clamped > {1'b0, cfg.fast_coef}) ? {1'b0, cfg.fast_coef}
                                                           : lo_clamped;

  assign diff    = {sample[SW-1], sample} - {held[SW-1], held};
  assign ratio_s = {1'b0, ratio};
  assign prod    = PW'(ratio_s) * PW'(diff);
  assign total   = {{4{held[SW-1]}}, held, 16'b0} + {{(TW-PW){prod[PW-1]}}, prod};

  // Round to nearest with halves away from zero on the magnitude.
  assign neg     = total[TW-1];
  assign mag     = neg ? (TW'(0) - TW'(total)) : TW'(total);
  assign mag_rnd = mag + TW'(32768);
  assign rnd     = {1'b0, mag_rnd[TW-1:16]};
  assign q       = neg ? (QW'(0) - rnd) : rnd;

  always_comb begin
    if (q > Q_MAX) begin
      filtered = Q_MAX[SW-1:0];
    end else if (q < Q_MIN) begin
      filtered = Q_MIN[SW-1:0];
    end else begin
      filtered = q[SW-1:0];
    end
  end

  always_comb begin
    if (action == ACT_PRELOAD) begin
      held_next  = sample;
      accel_next = cfg.slow_coef;
    end else begin
      held_next  = filtered;
      accel_next = hi_clamped[RATIO_W-1:0];
    end
  end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for accel_asym_lowpass_unit: directed and random requests, each
// result checked against an in-bench model of the asymmetric accelerating filter or a table value.
// Depends on rtl/accel_lp_pkg.sv and rtl/accel_asym_lowpass_unit.sv.
`timescale 1ns / 1ps

module testbench;
  import accel_lp_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int TDATA_W = ((SW + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTINGS_PER_PHASE = 2;
  localparam int ITEMS_PER_SETTING = 92;
  localparam int SETTLE_CYCLES = 4;
  localparam int PRINT_CAP = 40;
  localparam int N_PHASES = 4;
  localparam int N_ROWS = 29;
  localparam longint SAT_MAX = (longint'(1) << (SW - 1)) - 1;
  localparam longint SAT_MIN = -SAT_MAX - 1;

  typedef enum logic [1:0] {ROW_STEP, ROW_PRELOAD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    logic [SW-1:0]          smp;
    logic                   has_exp;
    logic [SW-1:0]          exp_val;
  } row_t;

  // Starts from the reset state, then walks through saturation, reversed clamp
  // bounds and the extremes of the growth and shrink factors.
  row_t directed_rows [N_ROWS] = '{
    '{ROW_STEP,    REG_MAX_HOLD_MODE, 17'd0,      16'hff9c, 1'b1, 16'h0000},
    '{ROW_STEP,    REG_MAX_HOLD_MODE, 17'd0,      16'h7fff, 1'b1, 16'h4000},
    '{ROW_PRELOAD, REG_MAX_HOLD_MODE, 17'd0,      16'h7fff, 1'b0, 16'h0000},
    '{ROW_STEP,    REG_MAX_HOLD_MODE, 17'd0,      16'h7fff, 1'b1, 16'h7fff},
    '{ROW_STEP,    REG_MAX_HOLD_MODE, 17'd0,      16'h8000, 1'b0, 16'h0000},
    '{ROW_STEP,    REG_MAX_HOLD_MODE, 17'd0,      16'h8000, 1'b0, 16'h0000},
    '{ROW_PRELOAD, REG_MAX_HOLD_MODE, 17'd0,      16'h8000, 1'b0, 16'h0000},
    '{ROW_STEP,    REG_MAX_HOLD_MODE, 17'd0,      16'h8000, 1'b1, 16'h8000},
    '{ROW_STEP,    REG_MAX_HOLD_MODE, 17'd0,      16'h0000, 1'b0, 16'h0000},
    '{ROW_CFG,     REG_FAST_COEF,     17'd131071, 16'h0000, 1'b0, 16'h0000},
    '{ROW_PRELOAD, REG_MAX_HOLD_MODE, 17'd0,      16'h0000, 1'b0, 16'h0000},
    '{ROW_STEP,    REG_MAX_HOLD_MODE, 17'd0,      16'h7fff, 1'b1, 16'h7fff},
    '{ROW_CFG,     REG_MAX_HOLD_MODE, 17'd0,      16'h0000, 1'b0, 16'h0000},
    '{ROW_PRELOAD, REG_MAX_HOLD_MODE, 17'd0,      16'h0000, 1'b0, 16'h0000},
    '{ROW_STEP,    REG_MAX_HOLD_MODE, 17'd0,      16'h8000, 1'b1, 16'h8000},
    '{ROW_STEP,    REG_MAX_HOLD_MODE, 17'd0,      16'h7fff, 1'b0, 16'h0000},
    '{ROW_CFG,     REG_FAST_COEF,     17'd0,      16'h0000, 1'b0, 16'h0000},
    '{ROW_CFG,     REG_SLOW_COEF,     17'd65536,  16'h0000, 1'b0, 16'h0000},
    '{ROW_PRELOAD, REG_MAX_HOLD_MODE, 17'd0,      16'h0064, 1'b0, 16'h0000},
    '{ROW_STEP,    REG_MAX_HOLD_MODE, 17'd0,      16'h00c8, 1'b0, 16'h0000},
    '{ROW_STEP,    REG_MAX_HOLD_MODE, 17'd0,      16'h012c, 1'b0, 16'h0000},
    '{ROW_STEP,    REG_MAX_HOLD_MODE, 17'd0,      16'h0000, 1'b0, 16'h0000},
    '{ROW_CFG,     REG_SLOW_INCREASE, 17'd65535,  16'h0000, 1'b0, 16'h0000},
    '{ROW_CFG,     REG_SLOW_DECREASE, 17'd65535,  16'h0000, 1'b0, 16'h0000},
    '{ROW_CFG,     REG_FAST_COEF,     17'd65536,  16'h0000, 1'b0, 16'h0000},
    '{ROW_CFG,     REG_SLOW_COEF,     17'd0,      16'h0000, 1'b0, 16'h0000},
    '{ROW_PRELOAD, REG_MAX_HOLD_MODE, 17'd0,      16'h0000, 1'b0, 16'h0000},
    '{ROW_STEP,    REG_MAX_HOLD_MODE, 17'd0,      16'h7fff, 1'b0, 16'h0000},
    '{ROW_STEP,    REG_MAX_HOLD_MODE, 17'd0,      16'h8000, 1'b0, 16'h0000}
  };

  int send_idle_tab [N_PHASES] = '{0, 68, 0, 30};
  int recv_stall_tab [N_PHASES] = '{0, 0, 68, 30};

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [TDATA_W-1:0]     s_tdata = '0;   // [SW-1:0] sample
  logic                   s_tuser = 1'b0; // [0] action
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_W-1:0]     m_tdata;        // [SW-1:0] filtered

  // Expectation typed into the table for the request currently on the bus.
  logic                   table_exp_set = 1'b0;
  logic [SW-1:0]          table_exp = '0;

  // Model state and shadow of the configuration registers.
  cfg_t                   model_cfg = '{RST_MAX_HOLD_MODE, RST_FAST_COEF, RST_SLOW_COEF,
                                        RST_SLOW_INCREASE, RST_SLOW_DECREASE};
  logic signed [SW-1:0]   held_model = '0;
  logic [RATIO_W-1:0]     accel_model = '0;
  logic [SW-1:0]          filtered_q [$];
  logic [SW-1:0]          want_filtered;

  int                     send_idle = 0;
  int                     recv_stall = 0;
  int                     mismatches = 0;
  int                     cycle_count = 0;
  row_t                   row;
  logic                   act;

  accel_asym_lowpass_unit #(.SAMPLE_WIDTH(SW)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count++;

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Advances the model by one accepted request; a step queues its filtered value, or the table value if given.
  task automatic filter_step(input logic req_act, input logic [SW-1:0] smp,
                             input logic use_table, input logic [SW-1:0] table_val);
    longint s, h, r, nxt, total, mag, q;
    logic   fast_dir;
    logic   neg;
    s = longint'($signed(smp));
    if (req_act == ACT_PRELOAD) begin
      held_model = smp;
      accel_model = model_cfg.slow_coef;
    end else begin
      h = longint'(held_model);
      fast_dir = model_cfg.max_hold_mode ? (s >= h) : (s <= h);
      if (fast_dir) begin
        r = longint'(model_cfg.fast_coef);
        nxt = (longint'(accel_model) *
               (longint'(ONE_Q16) - longint'(model_cfg.slow_decrease))) >>> 16;
      end else begin
        r = longint'(accel_model);
        nxt = (longint'(accel_model) *
               (longint'(ONE_Q16) + longint'(model_cfg.slow_increase))) >>> 16;
      end
      // Lower bound first, so the upper bound wins when the two are crossed.
      if (nxt < longint'(model_cfg.slow_coef)) nxt = longint'(model_cfg.slow_coef);
      if (nxt > longint'(model_cfg.fast_coef)) nxt = longint'(model_cfg.fast_coef);
      accel_model = nxt[RATIO_W-1:0];

      total = h * longint'(ONE_Q16) + r * (s - h);
      neg = total < 0;
      mag = neg ? -total : total;
      mag = (mag + 32768) >>> 16;
      q = neg ? -mag : mag;
      if (q > SAT_MAX) q = SAT_MAX;
      if (q < SAT_MIN) q = SAT_MIN;
      held_model = q[SW-1:0];
      filtered_q.push_back(use_table ? table_val : q[SW-1:0]);
    end
  endtask

  // Results are checked before the request of the same edge is modelled: a request
  // cannot produce its result at the edge at which it is accepted.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (filtered_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with none outstanding",
                                    $signed(m_tdata[SW-1:0])));
        end else begin
          want_filtered = filtered_q.pop_front();
          if (m_tdata !== TDATA_W'(want_filtered))
            report_mismatch($sformatf("filtered got %0d expected %0d",
                                      $signed(m_tdata[SW-1:0]), $signed(want_filtered)));
        end
      end
      if (s_tvalid && s_tready)
        filter_step(s_tuser, s_tdata[SW-1:0], table_exp_set, table_exp);
    end
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall);

  task automatic send_request(input logic req_act, input logic [SW-1:0] smp,
                              input logic use_table, input logic [SW-1:0] table_val);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= req_act;
    s_tdata <= TDATA_W'(smp);
    table_exp_set <= use_table;
    table_exp <= table_val;
    do @(posedge clk); while (!s_tready);
  endtask

  // Waits until every result is in, then lets a trailing preload settle.
  task automatic drain;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MAX_HOLD_MODE: model_cfg.max_hold_mode = val[0];
      REG_FAST_COEF:     model_cfg.fast_coef = val[RATIO_W-1:0];
      REG_SLOW_COEF:     model_cfg.slow_coef = val[RATIO_W-1:0];
      REG_SLOW_INCREASE: model_cfg.slow_increase = val[FRAC_W-1:0];
      REG_SLOW_DECREASE: model_cfg.slow_decrease = val[FRAC_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic apply_random_settings;
    cfg_t c;
    c.max_hold_mode = 1'($urandom_range(1));
    case ($urandom_range(5))
      0: c.fast_coef = '0;
      1: c.fast_coef = ONE_Q16;
      2: c.fast_coef = '1;
      default: c.fast_coef = RATIO_W'($urandom_range(65536, 4096));
    endcase
    case ($urandom_range(5))
      0: c.slow_coef = '0;
      1: c.slow_coef = ONE_Q16;
      2: c.slow_coef = RATIO_W'($urandom_range(131071));
      default: c.slow_coef = RATIO_W'($urandom_range(4096));
    endcase
    case ($urandom_range(4))
      0: c.slow_increase = '0;
      1: c.slow_increase = '1;
      2: c.slow_increase = FRAC_W'($urandom);
      default: c.slow_increase = FRAC_W'($urandom_range(8192));
    endcase
    case ($urandom_range(4))
      0: c.slow_decrease = '0;
      1: c.slow_decrease = '1;
      2: c.slow_decrease = FRAC_W'($urandom);
      default: c.slow_decrease = FRAC_W'($urandom_range(8192));
    endcase
    write_reg(REG_MAX_HOLD_MODE, CFG_DATA_W'(c.max_hold_mode));
    write_reg(REG_FAST_COEF, CFG_DATA_W'(c.fast_coef));
    write_reg(REG_SLOW_COEF, CFG_DATA_W'(c.slow_coef));
    write_reg(REG_SLOW_INCREASE, CFG_DATA_W'(c.slow_increase));
    write_reg(REG_SLOW_DECREASE, CFG_DATA_W'(c.slow_decrease));
  endtask

  // Mixes rail values, values equal or close to the held value, and full-range noise.
  function automatic logic [SW-1:0] random_sample;
    case ($urandom_range(9))
      0: return {1'b0, {(SW-1){1'b1}}};
      1: return {1'b1, {(SW-1){1'b0}}};
      2, 3: return held_model ^ SW'($urandom_range(31));
      4: return held_model;
      default: return SW'($urandom);
    endcase
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_ROWS; i++) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_CFG: begin
          drain();
          write_reg(row.reg_idx, row.reg_val);
        end
        ROW_PRELOAD: send_request(ACT_PRELOAD, row.smp, 1'b0, row.exp_val);
        default: send_request(ACT_STEP, row.smp, row.has_exp, row.exp_val);
      endcase
    end

    for (int phase = 0; phase < N_PHASES; phase++) begin
      drain();
      send_idle = send_idle_tab[phase];
      recv_stall = recv_stall_tab[phase];
      repeat (SETTINGS_PER_PHASE) begin
        drain();
        apply_random_settings();
        // Each run opens with a preload so the ratio starts from its configured value.
        send_request(ACT_PRELOAD, random_sample(), 1'b0, '0);
        repeat (ITEMS_PER_SETTING) begin
          act = ($urandom_range(19) == 0) ? ACT_PRELOAD : ACT_STEP;
          send_request(act, random_sample(), 1'b0, '0);
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* accel_asym_lowpass_unit.f */
rtl/accel_lp_pkg.sv
rtl/accel_lp_cfg.sv
rtl/accel_lp_step.sv
rtl/accel_asym_lowpass_unit.sv
tb/testbench.sv
